// ===== rtl/sti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_pkg: shared definitions for the sorted table
// Table depth, derived widths, status and command codes, and the control beat
// that is broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
package sti_pkg;

  localparam int DEPTH   = 16;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OCNT_W  = 5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Broadcast to all cells for one beat
  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [DATA_W-1:0] value;
  } ctl_t;

endpackage

// ===== rtl/sti_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_cell: one slot of the sorted chain
// Holds one value, compares it with the broadcast operand and takes the
// operand or a neighbor's value on insert/delete.
// ----------------------------------------------------------------------------
module sti_cell
  import sti_pkg::*;
(
  input  logic                     clk,
  input  ctl_t                     ctl,
  input  logic                     occ,       // slot lies below the fill count
  input  logic                     left_lt,   // left slot sits before the operand
  input  logic signed [DATA_W-1:0] left_val,
  input  logic signed [DATA_W-1:0] right_val,
  output logic                     lt,
  output logic                     eq,
  output logic signed [DATA_W-1:0] val
);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  assign lt  = occ && (val_r < ctl.value);
  assign eq  = occ && (val_r == ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && !lt) begin
      // shift right; the first slot past the smaller values takes the operand
      val_nxt = left_lt ? ctl.value : left_val;
    end else if (ctl.del_en && occ && !lt) begin
      // close the gap from the first match onward
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/sorted_table_insert_delete.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_delete: ascending table of signed values
// Row of DEPTH compare-and-shift cells with a shared fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive in_command (insert or delete), in_value and pulse
//   start. A beat is taken at each rising edge with start high and busy low.
//   busy stays low: every cell compares its slot with the operand in the same
//   cycle and shifts toward or away from its neighbor at the edge that takes
//   the beat, so a new beat may follow in the very next cycle.
//   Result channel: in the cycle after a beat is taken, out_strobe is high for
//   exactly one cycle with out_status, out_count and out_smallest. The
//   receiver cannot hold results off; they must be taken on that cycle.
//   Throughput: 1 beat per cycle, set by the compare/shift across the cell
//   row plus the one-of-DEPTH match OR.
//   Status: ok, value not found, table full (insert at DEPTH entries), or
//   table empty (delete with no entries); on any non-ok status the table
//   holds unchanged. out_smallest reads zero when the table is empty.
//   Reset: rst_n (synchronous, active low) clears the fill count and the
//   strobe; the cell contents are not cleared, only slots below the count
//   are ever looked at.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete
  import sti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_strobe,
  output logic [1:0]               out_status,
  output logic [OCNT_W-1:0]        out_count,
  output logic signed [DATA_W-1:0] out_smallest
);

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     strobe_r;
  status_t                  status_r;
  status_t                  status_nxt;
  ctl_t                     ctl;

  logic [DEPTH-1:0]         occ;
  logic [DEPTH-1:0]         lt;
  logic [DEPTH-1:0]         eq;
  logic signed [DATA_W-1:0] vals [DEPTH];

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     found;

  // Every beat completes at the edge that takes it, so the block never pushes back
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign found = |eq;

  // Decide the operation and its status from the current fill and match
  always_comb begin
    ctl.value  = in_value;
    ctl.ins_en = 1'b0;
    ctl.del_en = 1'b0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    if (in_command == CMD_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        ctl.ins_en = accept;
        count_nxt  = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else if (!found) begin
        status_nxt = ST_NOT_FOUND;
      end else begin
        ctl.del_en = accept;
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  // Cell row: each slot sees its neighbors' values and the left compare
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_lt;
    logic signed [DATA_W-1:0] left_val;
    logic signed [DATA_W-1:0] right_val;

    assign occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = in_value;
    end else begin : g_mid
      assign left_lt  = lt[i-1];
      assign left_val = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_inner
      assign right_val = vals[i+1];
    end

    sti_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (occ[i]),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .lt        (lt[i]),
      .eq        (eq[i]),
      .val       (vals[i])
    );
  end

  // Advance the count and post a result beat for every accepted command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // Results read the updated state directly; the first cell holds the minimum
  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_count    = OCNT_W'(count_r);
  assign out_smallest = (count_r != '0) ? vals[0] : '0;

endmodule

// ===== rtl/sti_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sti_checker: port-level checks for the sorted table
// Watches the command and result ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module sti_checker
  import sti_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     in_command,
  input logic                     out_strobe,
  input logic [1:0]               out_status,
  input logic [OCNT_W-1:0]        out_count,
  input logic signed [DATA_W-1:0] out_smallest
);

  // one result beat per taken command, in the following cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_strobe == $past(start && !busy)))
    else $error("result strobe does not follow the command beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_count == '0) |-> (out_smallest == '0))
    else $error("smallest not zero on an empty table");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> (out_count == OCNT_W'(DEPTH)))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with nonzero count");

  // a rejected delete must come from a delete command
  a_delete_status: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_INSERT)
      |=> (out_status == ST_OK || out_status == ST_FULL))
    else $error("insert reported a delete-only status");

endmodule

bind sorted_table_insert_delete sti_checker u_sti_checker (.*);

// ===== tb/sorted_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_checker: result scoreboard for the sorted table
// Watches the command and result channels, keeps a shadow copy of the table,
// predicts status, count and smallest value per command beat and compares.
// ----------------------------------------------------------------------------
module sorted_table_checker
  import sti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic                     in_command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_strobe,
  input  logic [1:0]               out_status,
  input  logic [OCNT_W-1:0]        out_count,
  input  logic signed [DATA_W-1:0] out_smallest,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    status_t                  status;
    logic [OCNT_W-1:0]        count;
    logic signed [DATA_W-1:0] smallest;
  } table_result_t;

  logic signed [DATA_W-1:0] shadow_vals [DEPTH];
  int                       shadow_fill = 0;
  int                       error_tally = 0;
  table_result_t            awaited_results [$];

  // Apply one command to the shadow table and return the result it yields
  function automatic table_result_t predict_table_update(
    input logic                     cmd,
    input logic signed [DATA_W-1:0] val
  );
    table_result_t res;
    int            pos;
    int            i;
    pos        = 0;
    res.status = ST_OK;
    if (cmd == CMD_INSERT) begin
      if (shadow_fill >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        while (pos < shadow_fill && shadow_vals[pos] < val) pos++;
        for (i = shadow_fill; i > pos; i--) shadow_vals[i] = shadow_vals[i-1];
        shadow_vals[pos] = val;
        shadow_fill++;
      end
    end else if (shadow_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      while (pos < shadow_fill && shadow_vals[pos] != val) pos++;
      if (pos >= shadow_fill) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (i = pos; i + 1 < shadow_fill; i++) shadow_vals[i] = shadow_vals[i+1];
        shadow_fill--;
      end
    end
    res.count    = OCNT_W'(shadow_fill);
    res.smallest = (shadow_fill > 0) ? shadow_vals[0] : '0;
    return res;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      awaited_results.delete();
    end else begin
      // Retire the result first: it belongs to an earlier taken beat
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no command waiting");
          error_tally++;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            error_tally++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_count);
            error_tally++;
          end
          if (out_smallest !== want.smallest) begin
            $error("smallest: expected %0d, actual %0d", want.smallest, out_smallest);
            error_tally++;
          end
        end
      end
      if (start && !busy) awaited_results.push_back(predict_table_update(in_command, in_value));
    end
    pending    <= awaited_results.size();
    fail_count <= error_tally;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the sorted table
// Drives directed and random insert/delete beats with random gaps into the
// table, lets the checker score every result, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import sti_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int RESET_CYCLES   = 10;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     start      = 1'b0;
  logic                     in_command = CMD_INSERT;
  logic signed [DATA_W-1:0] in_value   = '0;
  logic                     busy;
  logic                     out_strobe;
  logic [1:0]               out_status;
  logic [OCNT_W-1:0]        out_count;
  logic signed [DATA_W-1:0] out_smallest;

  int fail_count;
  int pending;
  int quiet_cycles = 0;
  int idle_style   = 2;   // 0 back to back, 1 sparse gaps, 2 a random gap per beat
  int insert_bias  = 50;  // percent of random beats that insert

  always #6 clk = ~clk;

  sorted_table_insert_delete u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_smallest (out_smallest)
  );

  sorted_table_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_smallest (out_smallest),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Watchdog: end the run if no beat moves on either channel for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle for a gap chosen by idle_style, then present one command beat and
  // hold it until taken. Leave start high so a back-to-back beat follows
  // without a low-then-high in the same step.
  task automatic send_beat(input logic cmd, input logic signed [DATA_W-1:0] val);
    int gap;
    case (idle_style)
      0: gap = 0;
      1: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
      default: gap = $urandom_range(0, 15);
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= val;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Favor small values so duplicates and delete hits are common; mix in the
  // extremes and fully random words so every value bit toggles
  function automatic logic signed [DATA_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return DATA_W'($urandom_range(0, 6)) - 3;
    if (pick < 65) begin
      case ($urandom_range(0, 4))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        3: return VAL_MAX - 1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int n;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: delete from an empty table
    send_beat(CMD_DELETE, 5);
    // Extremes of the value range, then an equal value in front of its twin
    send_beat(CMD_INSERT, VAL_MAX);
    send_beat(CMD_INSERT, VAL_MIN);
    send_beat(CMD_INSERT, 0);
    send_beat(CMD_INSERT, -1);
    send_beat(CMD_INSERT, 0);
    // Delete of an absent value, then of the first of two equal values
    send_beat(CMD_DELETE, 7);
    send_beat(CMD_DELETE, 0);
    // Fill to DEPTH (one value repeats an existing entry), then overfill
    for (n = 0; n < DEPTH - 4; n++) send_beat(CMD_INSERT, n * 3 - 10);
    send_beat(CMD_INSERT, 1);
    // Remove the smallest from the full table, then the largest
    send_beat(CMD_DELETE, VAL_MIN);
    send_beat(CMD_DELETE, VAL_MAX);

    // Random: drift between filling and draining so both empty and full
    // edges are hit repeatedly, and vary the gap style in stretches
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_bias = 25;
          1: insert_bias = 50;
          default: insert_bias = 75;
        endcase
      end
      if (n % 256 == 0) idle_style = $urandom_range(0, 2);
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_beat(($urandom_range(0, 99) < insert_bias) ? CMD_INSERT : CMD_DELETE,
                pick_value());
    end

    // Drain, let the checker's tally settle, then give the verdict
    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sorted_table_insert_delete.f =====
rtl/sti_pkg.sv
rtl/sti_cell.sv
rtl/sorted_table_insert_delete.sv
rtl/sti_checker.sv
tb/sorted_table_checker.sv
tb/tb.sv
